// ----- hw/rtl/reb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reb_pkg
// Shared types and codes for the rotary encoder and push button decoder.
// ----------------------------------------------------------------------------
package reb_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int FAST_W      = 8;
    localparam int PRESS_CFG_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_FAST_INTERVAL   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VERY_LONG_PRESS = 2'd2;

    // Reset values of the configuration registers
    localparam logic [FAST_W-1:0]      FAST_INTERVAL_RST   = 8'd10;
    localparam logic [PRESS_CFG_W-1:0] LONG_PRESS_RST      = 16'd100;
    localparam logic [PRESS_CFG_W-1:0] VERY_LONG_PRESS_RST = 16'd300;

    // Rotation codes
    localparam logic [1:0] ROT_NONE = 2'd0;
    localparam logic [1:0] ROT_CW   = 2'd1;
    localparam logic [1:0] ROT_CCW  = 2'd2;

    // Button event codes
    localparam logic [1:0] BTN_NONE      = 2'd0;
    localparam logic [1:0] BTN_SHORT     = 2'd1;
    localparam logic [1:0] BTN_LONG      = 2'd2;
    localparam logic [1:0] BTN_VERY_LONG = 2'd3;

    // Thresholds handed from the register file to the decoders
    typedef struct packed {
        logic [FAST_W-1:0]      fast_interval;
        logic [PRESS_CFG_W-1:0] long_press_ticks;
        logic [PRESS_CFG_W-1:0] very_long_press_ticks;
    } reb_cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/reb_quad.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reb_quad
// Quadrature step decoder with a saturating gap counter for fast steps.
// ----------------------------------------------------------------------------
module reb_quad
    import reb_pkg::*;
#(
    parameter int GAP_WIDTH = 8
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_en,
    input  wire logic       pin_a,
    input  wire logic       pin_b,
    input  wire reb_cfg_t   cfg,
    output logic [1:0]      rotation,
    output logic            fast
);

    localparam int GCW = (GAP_WIDTH > FAST_W) ? GAP_WIDTH : FAST_W;
    localparam logic [GAP_WIDTH-1:0] GAP_MAX = {GAP_WIDTH{1'b1}};

    logic                 last_a_reg, last_a_next;
    logic                 held_b_reg, held_b_next;
    logic [GAP_WIDTH-1:0] gap_reg, gap_next;
    logic [GAP_WIDTH-1:0] gap_inc;
    logic [GCW-1:0]       gap_ext, gap_inc_ext, fi_ext;

    assign fi_ext  = GCW'(cfg.fast_interval);
    assign gap_ext = GCW'(gap_reg);

    // Advance the gap counter while below the fast interval and its maximum
    always_comb begin
        if (gap_reg != '0 && gap_ext < fi_ext && gap_reg != GAP_MAX) begin
            gap_inc = gap_reg + GAP_WIDTH'(1);
        end else begin
            gap_inc = gap_reg;
        end
    end

    assign gap_inc_ext = GCW'(gap_inc);

    // Latch B on a falling A, decode direction on a rising A
    always_comb begin
        rotation    = ROT_NONE;
        held_b_next = held_b_reg;
        if (last_a_reg) begin
            if (!pin_a) begin
                held_b_next = pin_b;
            end
        end else if (pin_a) begin
            if (pin_b && !held_b_reg) begin
                rotation = ROT_CW;
            end else if (!pin_b && held_b_reg) begin
                rotation = ROT_CCW;
            end
        end
        last_a_next = pin_a;
        fast        = 1'b0;
        gap_next    = gap_inc;
        if (rotation != ROT_NONE) begin
            fast     = (gap_inc != '0) && (gap_inc_ext < fi_ext);
            gap_next = GAP_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_a_reg <= 1'b1;
            held_b_reg <= 1'b1;
            gap_reg    <= '0;
        end else if (step_en) begin
            last_a_reg <= last_a_next;
            held_b_reg <= held_b_next;
            gap_reg    <= gap_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/reb_button.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reb_button
// Press length counter for the active-low push button.
// ----------------------------------------------------------------------------
module reb_button
    import reb_pkg::*;
#(
    parameter int PRESS_WIDTH = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_en,
    input  wire logic       pin_button,
    input  wire reb_cfg_t   cfg,
    output logic [1:0]      button_event
);

    localparam int PCW = (PRESS_WIDTH > PRESS_CFG_W) ? PRESS_WIDTH : PRESS_CFG_W;
    localparam logic [PRESS_WIDTH-1:0] PRESS_MAX = {PRESS_WIDTH{1'b1}};

    logic                   last_btn_reg;
    logic [PRESS_WIDTH-1:0] press_reg, press_next;
    logic [PRESS_WIDTH-1:0] press_inc;
    logic [PCW-1:0]         press_ext, press_inc_ext, long_ext, vlong_ext;

    assign press_inc     = (press_reg == PRESS_MAX) ? press_reg : press_reg + PRESS_WIDTH'(1);
    assign press_ext     = PCW'(press_reg);
    assign press_inc_ext = PCW'(press_inc);
    assign long_ext      = PCW'(cfg.long_press_ticks);
    assign vlong_ext     = PCW'(cfg.very_long_press_ticks);

    // Classify on release, report very long while held
    always_comb begin
        button_event = BTN_NONE;
        press_next   = press_reg;
        if (pin_button) begin
            if (!last_btn_reg) begin
                if (press_ext >= long_ext) begin
                    button_event = BTN_LONG;
                end else if (press_reg != '0) begin
                    button_event = BTN_SHORT;
                end
            end
            press_next = '0;
        end else if (last_btn_reg) begin
            press_next = PRESS_WIDTH'(1);
        end else if (press_reg != '0) begin
            if (press_inc_ext > vlong_ext) begin
                button_event = BTN_VERY_LONG;
                press_next   = '0;
            end else begin
                press_next = press_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_btn_reg <= 1'b1;
            press_reg    <= '0;
        end else if (step_en) begin
            last_btn_reg <= pin_button;
            press_reg    <= press_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/rotary_encoder_button_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotary_encoder_button_decoder
// Decodes encoder steps, fast stepping and button press lengths, one result
// word for every sample word.
//
//   channel | ports                               | direction
//   --------+-------------------------------------+----------
//   sample  | s_valid s_ready s_pin_a/b/button    | in
//   result  | m_valid m_ready m_rotation/fast/    | out
//           | m_button_event                      |
//   config  | cfg_wr_en cfg_index cfg_wdata       | in
//
// One word per cycle while the result side is ready; a word goes from the
// input register to the result register, with all decode work between them.
// Reset (aresetn, synchronous) restores thresholds 10/100/300 and clears state.
// A stalled result holds the result register; a new sample is still taken
// while the result register frees up in the same cycle.
// ----------------------------------------------------------------------------
module rotary_encoder_button_decoder
    import reb_pkg::*;
#(
    parameter int GAP_WIDTH   = 8,
    parameter int PRESS_WIDTH = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_pin_a,
    input  wire logic                   s_pin_b,
    input  wire logic                   s_pin_button,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [1:0]                  m_rotation,
    output logic                        m_fast,
    output logic [1:0]                  m_button_event
);

    reb_cfg_t   cfg_reg;
    logic       in_valid_reg;
    logic       in_a_reg, in_b_reg, in_btn_reg;
    logic       out_valid_reg;
    logic [1:0] out_rot_reg;
    logic       out_fast_reg;
    logic [1:0] out_evt_reg;
    logic       advance;
    logic       s_accept;
    logic [1:0] rotation;
    logic       fast;
    logic [1:0] button_event;

    // Configuration register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_interval         <= FAST_INTERVAL_RST;
            cfg_reg.long_press_ticks      <= LONG_PRESS_RST;
            cfg_reg.very_long_press_ticks <= VERY_LONG_PRESS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FAST_INTERVAL:   cfg_reg.fast_interval <= cfg_wdata[FAST_W-1:0];
                REG_LONG_PRESS:      cfg_reg.long_press_ticks <= cfg_wdata;
                REG_VERY_LONG_PRESS: cfg_reg.very_long_press_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Move a word from the input register when the result register frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_a_reg   <= s_pin_a;
            in_b_reg   <= s_pin_b;
            in_btn_reg <= s_pin_button;
        end
    end

    reb_quad #(
        .GAP_WIDTH (GAP_WIDTH)
    ) u_quad (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .pin_a    (in_a_reg),
        .pin_b    (in_b_reg),
        .cfg      (cfg_reg),
        .rotation (rotation),
        .fast     (fast)
    );

    // Skip button handling on ticks that report a step
    reb_button #(
        .PRESS_WIDTH (PRESS_WIDTH)
    ) u_button (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (advance && (rotation == ROT_NONE)),
        .pin_button   (in_btn_reg),
        .cfg          (cfg_reg),
        .button_event (button_event)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_rot_reg  <= rotation;
            out_fast_reg <= fast;
            out_evt_reg  <= (rotation == ROT_NONE) ? button_event : BTN_NONE;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_rotation     = out_rot_reg;
    assign m_fast         = out_fast_reg;
    assign m_button_event = out_evt_reg;

endmodule
`default_nettype wire

// ----- dv/tb_rotary_encoder_button_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotary_encoder_button_decoder
// Self-checking bench for the encoder and push button decoder. A queue of
// sample words feeds a bursty driver. A predictor computes the
// result word for every accepted sample, and a monitor compares it with the
// DUT output while the result side stalls on its own pattern. Directed words
// cover step directions, fast steps, press lengths and register extremes.
// Random phases follow with quadrature detents, broken sequences and noise.
// A final directed run walks the gap counter up to its cap.
// ----------------------------------------------------------------------------
module tb_rotary_encoder_button_decoder;
    import reb_pkg::*;

    localparam int GAP_W       = 8;
    localparam int PRESS_W     = 16;
    localparam int CYCLE_LIMIT = 100000;

    localparam logic [GAP_W-1:0]       GAP_TOP   = '1;
    localparam logic [PRESS_W-1:0]     PRESS_TOP = '1;
    // Index past the register list; writes to it are dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    // Detent paths as four (A,B) states, oldest first
    localparam logic [7:0] CW_PATH  = 8'b10_00_01_11;
    localparam logic [7:0] CCW_PATH = 8'b01_00_10_11;
    localparam logic [7:0] CW_HALF  = 8'b10_00_10_11;
    localparam logic [7:0] CCW_HALF = 8'b01_00_01_11;

    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic pin_button;
    } sample_t;

    typedef struct packed {
        logic [1:0] rotation;
        logic       fast;
        logic [1:0] button_event;
    } decoded_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_FAST_INTERVAL;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic                   s_pin_a      = 1'b1;
    logic                   s_pin_b      = 1'b1;
    logic                   s_pin_button = 1'b1;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [1:0]             m_rotation;
    logic                   m_fast;
    logic [1:0]             m_button_event;

    rotary_encoder_button_decoder u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pin_a        (s_pin_a),
        .s_pin_b        (s_pin_b),
        .s_pin_button   (s_pin_button),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rotation     (m_rotation),
        .m_fast         (m_fast),
        .m_button_event (m_button_event)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor state and threshold mirror
    // ------------------------------------------------------------------------
    logic [FAST_W-1:0]      thr_fast      = FAST_INTERVAL_RST;
    logic [PRESS_CFG_W-1:0] thr_long      = LONG_PRESS_RST;
    logic [PRESS_CFG_W-1:0] thr_very_long = VERY_LONG_PRESS_RST;

    logic               enc_last_a = 1'b1;
    logic               enc_held_b = 1'b1;
    logic               btn_last   = 1'b1;
    logic [GAP_W-1:0]   gap_ticks  = '0;
    logic [PRESS_W-1:0] press_cnt  = '0;

    sample_t  pending_samples[$];
    decoded_t expected_decodes[$];

    int unsigned gen_cnt      = 0;
    logic        gen_btn      = 1'b1;
    int unsigned gen_btn_left = 0;
    int unsigned setting_cnt  = 1;

    int unsigned err_cnt      = 0;
    int unsigned results_seen = 0;
    int unsigned cw_cnt       = 0;
    int unsigned ccw_cnt      = 0;
    int unsigned fast_cnt     = 0;
    int unsigned evt_cnt[4]   = '{0, 0, 0, 0};
    int unsigned cycle_cnt    = 0;

    // Advance the decoder by one sample tick and return its result word
    function automatic decoded_t decode_sample(input sample_t smp);
        decoded_t res;
        res.rotation     = ROT_NONE;
        res.fast         = 1'b0;
        res.button_event = BTN_NONE;

        // Gap counter runs only after a first step, up to the interval
        if (gap_ticks != '0 && gap_ticks < thr_fast && gap_ticks != GAP_TOP)
            gap_ticks = gap_ticks + 1'b1;

        if (enc_last_a) begin
            if (!smp.pin_a)
                enc_held_b = smp.pin_b;
        end else if (smp.pin_a) begin
            if (smp.pin_b && !enc_held_b)
                res.rotation = ROT_CW;
            else if (!smp.pin_b && enc_held_b)
                res.rotation = ROT_CCW;
        end
        if (res.rotation != ROT_NONE) begin
            res.fast  = (gap_ticks != '0) && (gap_ticks < thr_fast);
            gap_ticks = GAP_W'(1);
        end
        enc_last_a = smp.pin_a;

        // Skip the button on a step tick
        if (res.rotation == ROT_NONE) begin
            if (smp.pin_button) begin
                if (!btn_last) begin
                    if (press_cnt >= thr_long)
                        res.button_event = BTN_LONG;
                    else if (press_cnt != '0)
                        res.button_event = BTN_SHORT;
                end
                press_cnt = '0;
            end else if (btn_last) begin
                press_cnt = PRESS_W'(1);
            end else if (press_cnt != '0) begin
                if (press_cnt != PRESS_TOP)
                    press_cnt = press_cnt + 1'b1;
                if (press_cnt > thr_very_long) begin
                    res.button_event = BTN_VERY_LONG;
                    press_cnt        = '0;
                end
            end
            btn_last = smp.pin_button;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Sample generation
    // ------------------------------------------------------------------------
    task automatic push_sample(input logic a, input logic b, input logic btn);
        sample_t smp;
        smp.pin_a      = a;
        smp.pin_b      = b;
        smp.pin_button = btn;
        pending_samples.push_back(smp);
        gen_cnt++;
    endtask

    task automatic push_hold(input logic a, input logic b, input logic btn,
                             input int unsigned count);
        repeat (count) push_sample(a, b, btn);
    endtask

    // One tick with the button following its press/release plan
    task automatic push_tick(input logic a, input logic b);
        int unsigned len;
        if (gen_btn_left == 0) begin
            if (gen_btn) begin
                gen_btn = 1'b0;
                case ($urandom_range(0, 2))
                    0:       len = $urandom_range(1, (int'(thr_long) > 1) ? int'(thr_long) - 1 : 1);
                    1:       len = $urandom_range(int'(thr_long), int'(thr_long) + 6);
                    default: len = int'(thr_very_long) + $urandom_range(1, 6);
                endcase
                if (len > 300)
                    len = $urandom_range(1, 300);
                gen_btn_left = len;
            end else begin
                gen_btn      = 1'b1;
                gen_btn_left = $urandom_range(1, 25);
            end
        end
        gen_btn_left--;
        push_sample(a, b, gen_btn);
    endtask

    task automatic push_path(input logic [7:0] path, input int unsigned dwell_max);
        for (int i = 3; i >= 0; i--)
            repeat ($urandom_range(1, dwell_max)) push_tick(path[2*i+1], path[2*i]);
    endtask

    // Mostly clean detents, some broken ones, idle ticks and raw noise
    task automatic run_random(input int unsigned n);
        int unsigned stop_at;
        int unsigned dwell;
        stop_at = gen_cnt + n;
        while (gen_cnt < stop_at) begin
            dwell = $urandom_range(1, (thr_fast > 90) ? 30 : int'(thr_fast) / 3 + 2);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push_path(CW_PATH, dwell);
                4, 5, 6:    push_path(CCW_PATH, dwell);
                7:          push_path($urandom_range(0, 1) ? CW_HALF : CCW_HALF, dwell);
                8:          repeat ($urandom_range(1, 12)) push_tick(1'b1, 1'b1);
                default:
                    repeat ($urandom_range(1, 4))
                        push_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1)));
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Configuration writes, only while the block is idle
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FAST_INTERVAL:   thr_fast      = val[FAST_W-1:0];
            REG_LONG_PRESS:      thr_long      = val[PRESS_CFG_W-1:0];
            REG_VERY_LONG_PRESS: thr_very_long = val[PRESS_CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_cfg(input logic [CFG_DATA_W-1:0] fast_val,
                             input logic [CFG_DATA_W-1:0] long_val,
                             input logic [CFG_DATA_W-1:0] very_val);
        write_reg(REG_FAST_INTERVAL, fast_val);
        write_reg(REG_LONG_PRESS, long_val);
        write_reg(REG_VERY_LONG_PRESS, very_val);
        setting_cnt++;
    endtask

    // Wait until every sample is sent and every result word checked
    task automatic wait_drained();
        while (pending_samples.size() != 0 || s_valid || expected_decodes.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: bursts of words with random gaps
    // ------------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge aclk) begin : drive_samples
        sample_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // Predict on acceptance
            if (s_valid && s_ready)
                expected_decodes.push_back(decode_sample({s_pin_a, s_pin_b, s_pin_button}));
            if (!s_valid || s_ready) begin
                if (gap_left != 0 || pending_samples.size() == 0) begin
                    if (gap_left != 0)
                        gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    nxt = pending_samples.pop_front();
                    s_valid      <= 1'b1;
                    s_pin_a      <= nxt.pin_a;
                    s_pin_b      <= nxt.pin_b;
                    s_pin_button <= nxt.pin_button;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern, plus long holds to back up the input
    // ------------------------------------------------------------------------
    int unsigned rx_mode      = 0;
    int unsigned rx_mode_cnt  = 0;
    int unsigned hold_left    = 0;
    int unsigned holds_done   = 0;
    int unsigned next_hold_at = 150;

    always @(posedge aclk) begin
        rx_mode_cnt++;
        if (rx_mode_cnt == 48) begin
            rx_mode_cnt = 0;
            rx_mode     = $urandom_range(0, 3);
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (holds_done < 2 && results_seen >= next_hold_at
                     && pending_samples.size() > 40) begin
            hold_left = 120;
            holds_done++;
            next_hold_at += 300;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                2:       m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ~m_ready;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each result word with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        decoded_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_decodes.size() == 0) begin
                err_cnt++;
                $display("%0t: result word with none expected: rot %0d fast %0d btn %0d",
                         $time, m_rotation, m_fast, m_button_event);
            end else begin
                want = expected_decodes.pop_front();
                results_seen++;
                if (m_rotation !== want.rotation) begin
                    err_cnt++;
                    $display("%0t: rotation expected %0d, got %0d",
                             $time, want.rotation, m_rotation);
                end
                if (m_fast !== want.fast) begin
                    err_cnt++;
                    $display("%0t: fast expected %0d, got %0d", $time, want.fast, m_fast);
                end
                if (m_button_event !== want.button_event) begin
                    err_cnt++;
                    $display("%0t: button event expected %0d, got %0d",
                             $time, want.button_event, m_button_event);
                end
                if (want.rotation == ROT_CW)
                    cw_cnt++;
                if (want.rotation == ROT_CCW)
                    ccw_cnt++;
                if (want.fast)
                    fast_cnt++;
                evt_cnt[want.button_event]++;
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results checked", cycle_cnt, results_seen);
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        // Reset thresholds: steps both ways, a fast step, a step while held,
        // short presses
        push_sample(1'b1, 1'b1, 1'b1);
        push_sample(1'b1, 1'b0, 1'b1);
        push_sample(1'b0, 1'b0, 1'b1);
        push_sample(1'b1, 1'b1, 1'b1);
        push_sample(1'b0, 1'b1, 1'b1);
        push_sample(1'b0, 1'b0, 1'b1);
        push_sample(1'b1, 1'b0, 1'b1);
        push_sample(1'b1, 1'b1, 1'b0);
        push_sample(1'b0, 1'b0, 1'b0);
        push_sample(1'b1, 1'b1, 1'b0);
        push_sample(1'b1, 1'b1, 1'b1);
        push_sample(1'b1, 1'b1, 1'b0);
        push_sample(1'b1, 1'b1, 1'b1);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        wait_drained();

        // Zero fast interval, tiny press limits, a dropped write past the list
        write_cfg(16'd0, 16'd2, 16'd4);
        write_reg(REG_SPARE, 16'hFFFF);
        push_sample(1'b0, 1'b0, 1'b1);
        push_sample(1'b1, 1'b1, 1'b1);
        push_sample(1'b0, 1'b1, 1'b1);
        push_sample(1'b1, 1'b0, 1'b1);
        push_hold(1'b1, 1'b1, 1'b0, 2);
        push_sample(1'b1, 1'b1, 1'b1);
        push_hold(1'b1, 1'b1, 1'b0, 6);
        push_sample(1'b1, 1'b1, 1'b1);
        push_sample(1'b1, 1'b1, 1'b0);
        push_sample(1'b1, 1'b1, 1'b1);
        wait_drained();

        // Random phases across low, high and mixed thresholds
        write_cfg(16'd1, 16'd1, 16'd1);
        run_random(25);
        wait_drained();
        write_cfg(16'd255, 16'd65534, 16'd65534);
        run_random(25);
        wait_drained();
        write_cfg(16'd5, 16'd20, 16'd8);
        run_random(25);
        wait_drained();
        write_cfg(FAST_INTERVAL_RST, LONG_PRESS_RST, VERY_LONG_PRESS_RST);
        run_random(25);
        wait_drained();
        repeat (3) begin
            write_cfg(16'($urandom_range(2, 40)), 16'($urandom_range(2, 30)),
                      16'($urandom_range(5, 70)));
            run_random(25);
            wait_drained();
        end

        // Widest interval: gap just under and at its cap
        write_cfg(16'd255, 16'd65534, 16'hFFFF);
        push_sample(1'b1, 1'b1, 1'b1);
        push_sample(1'b1, 1'b0, 1'b1);
        push_sample(1'b0, 1'b0, 1'b1);
        push_sample(1'b1, 1'b1, 1'b1);
        push_hold(1'b1, 1'b1, 1'b1, 250);
        push_sample(1'b0, 1'b1, 1'b1);
        push_sample(1'b0, 1'b0, 1'b1);
        push_sample(1'b1, 1'b0, 1'b1);
        push_hold(1'b1, 1'b0, 1'b1, 252);
        push_sample(1'b0, 1'b0, 1'b1);
        push_sample(1'b1, 1'b1, 1'b1);
        wait_drained();
        repeat (8) @(posedge aclk);

        $display("covered %0d samples over %0d threshold settings: %0d cw, %0d ccw, %0d fast",
                 gen_cnt, setting_cnt, cw_cnt, ccw_cnt, fast_cnt);
        $display("button events: %0d short, %0d long, %0d very long; %0d mismatches",
                 evt_cnt[BTN_SHORT], evt_cnt[BTN_LONG], evt_cnt[BTN_VERY_LONG], err_cnt);
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/reb_pkg.sv
hw/rtl/reb_quad.sv
hw/rtl/reb_button.sv
hw/rtl/rotary_encoder_button_decoder.sv
dv/tb_rotary_encoder_button_decoder.sv
